// ----- rtl/core/bhc_pkg.sv -----
// Shared types and constants for the button hold classifier.
// No dependencies; imported by the core and its checker.
`timescale 1ns / 1ps

package bhc_pkg;

   localparam int HOLD_WIDTH_DEF = 16;
   localparam int LIMIT_W        = 16;
   localparam int COUNT_W        = 4;
   localparam int CSR_INDEX_W    = 3;

   localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST  = 16'd10;
   localparam logic [LIMIT_W-1:0] MEDIUM_LIMIT_RST = 16'd100;
   localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST   = 16'd500;
   localparam logic [COUNT_W-1:0] MODE_COUNT_RST   = 4'd11;
   localparam logic [COUNT_W-1:0] SCHEME_COUNT_RST = 4'd13;
   localparam logic [COUNT_W-1:0] NUMBER_FIRST     = 4'd1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHORT_LIMIT  = 3'd0,
      CSR_MEDIUM_LIMIT = 3'd1,
      CSR_LONG_LIMIT   = 3'd2,
      CSR_MODE_COUNT   = 3'd3,
      CSR_SCHEME_COUNT = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_SCHEME = 2'd1,
      ACT_MODE   = 2'd2,
      ACT_POWER  = 2'd3
   } action_type;

endpackage

// ----- rtl/core/button_hold_classifier_core.sv -----
// Button hold classifier core: hold counting, release classification, state.
// Depends on bhc_pkg.
`timescale 1ns / 1ps

// One button sample is taken per clock and the block sustains one item per cycle
// while neither side is stalled. A sample lands in the input register; once the
// output side is free, the state update and the result are computed in one pass
// and loaded into the result register. A stalled result holds the input
// register, which then stalls the input side. Each result reports the action
// taken and the power, mode, scheme and auto-cycle state after that sample. The
// hold counter saturates at its all-ones value. Limits and counts are written
// through the csr port, which is always ready; write it only while the block is
// idle.
module button_hold_classifier_core
   import bhc_pkg::*;
#(
   parameter int HOLD_WIDTH = HOLD_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_button_level,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_action,
   output logic                   rsp_power_on,
   output logic [COUNT_W-1:0]     rsp_mode_number,
   output logic [COUNT_W-1:0]     rsp_scheme_number,
   output logic                   rsp_auto_cycle,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]     csr_wdata
);

   localparam int CMP_W = (HOLD_WIDTH > LIMIT_W) ? HOLD_WIDTH : LIMIT_W;

   logic [LIMIT_W-1:0]    short_limit_ff, medium_limit_ff, long_limit_ff;
   logic [COUNT_W-1:0]    mode_count_ff, scheme_count_ff;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_level_ff;

   logic [HOLD_WIDTH-1:0] hold_count_ff, hold_count_in;
   logic                  last_pressed_ff, last_pressed_in;
   logic                  power_ff, power_in;
   logic [COUNT_W-1:0]    mode_ff, mode_in;
   logic [COUNT_W-1:0]    scheme_ff, scheme_in;
   logic                  cycle_ff, cycle_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   action_type            action_ff, action_in;
   logic                  out_power_ff;
   logic [COUNT_W-1:0]    out_mode_ff, out_scheme_ff;
   logic                  out_cycle_ff;

   logic                  out_free, advance, req_take, pressed;
   logic [CMP_W-1:0]      hold_ext;
   logic [COUNT_W:0]      mode_sum, scheme_sum;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign pressed    = !s1_level_ff;
   assign hold_ext   = CMP_W'(hold_count_ff);
   assign mode_sum   = {1'b0, mode_ff} + (COUNT_W+1)'(1);
   assign scheme_sum = {1'b0, scheme_ff} + (COUNT_W+1)'(1);

   always_comb begin
      s1_valid_in     = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in    = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      hold_count_in   = hold_count_ff;
      last_pressed_in = last_pressed_ff;
      power_in        = power_ff;
      mode_in         = mode_ff;
      scheme_in       = scheme_ff;
      cycle_in        = cycle_ff;
      action_in       = ACT_NONE;
      if (advance) begin
         last_pressed_in = pressed;
         if (pressed && (hold_count_ff != '1)) begin
            hold_count_in = hold_count_ff + HOLD_WIDTH'(1);
         end
         if (!pressed && !last_pressed_ff) begin
            hold_count_in = '0;
            if (hold_ext > CMP_W'(long_limit_ff)) begin
               action_in = ACT_POWER;
               power_in  = !power_ff;
            end else if (hold_ext > CMP_W'(medium_limit_ff)) begin
               action_in = ACT_MODE;
               mode_in   = (mode_sum > {1'b0, mode_count_ff}) ? NUMBER_FIRST
                                                               : mode_sum[COUNT_W-1:0];
            end else if (hold_ext > CMP_W'(short_limit_ff)) begin
               action_in = ACT_SCHEME;
               if (cycle_ff) begin
                  cycle_in  = 1'b0;
                  scheme_in = NUMBER_FIRST;
               end else if (scheme_sum > {1'b0, scheme_count_ff}) begin
                  cycle_in  = 1'b1;
                  scheme_in = NUMBER_FIRST;
               end else begin
                  scheme_in = scheme_sum[COUNT_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_limit_ff  <= SHORT_LIMIT_RST;
         medium_limit_ff <= MEDIUM_LIMIT_RST;
         long_limit_ff   <= LONG_LIMIT_RST;
         mode_count_ff   <= MODE_COUNT_RST;
         scheme_count_ff <= SCHEME_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SHORT_LIMIT:  short_limit_ff  <= csr_wdata;
            CSR_MEDIUM_LIMIT: medium_limit_ff <= csr_wdata;
            CSR_LONG_LIMIT:   long_limit_ff   <= csr_wdata;
            CSR_MODE_COUNT:   mode_count_ff   <= csr_wdata[COUNT_W-1:0];
            CSR_SCHEME_COUNT: scheme_count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         hold_count_ff   <= '0;
         last_pressed_ff <= 1'b0;
         power_ff        <= 1'b1;
         mode_ff         <= NUMBER_FIRST;
         scheme_ff       <= NUMBER_FIRST;
         cycle_ff        <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         hold_count_ff   <= hold_count_in;
         last_pressed_ff <= last_pressed_in;
         power_ff        <= power_in;
         mode_ff         <= mode_in;
         scheme_ff       <= scheme_in;
         cycle_ff        <= cycle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_level_ff <= req_button_level;
      end
      if (advance) begin
         action_ff     <= action_in;
         out_power_ff  <= power_in;
         out_mode_ff   <= mode_in;
         out_scheme_ff <= scheme_in;
         out_cycle_ff  <= cycle_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_action        = action_ff;
   assign rsp_power_on      = out_power_ff;
   assign rsp_mode_number   = out_mode_ff;
   assign rsp_scheme_number = out_scheme_ff;
   assign rsp_auto_cycle    = out_cycle_ff;

endmodule

// ----- rtl/core/bhc_checker.sv -----
// Port-level assertions for button_hold_classifier_core, bound into that module.
// Depends on bhc_pkg and button_hold_classifier_core.
`timescale 1ns / 1ps

module bhc_checker
   import bhc_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [1:0]         rsp_action,
   input logic               rsp_power_on,
   input logic [COUNT_W-1:0] rsp_mode_number,
   input logic [COUNT_W-1:0] rsp_scheme_number,
   input logic               rsp_auto_cycle
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action)
         && $stable(rsp_mode_number) && $stable(rsp_scheme_number)
         && $stable(rsp_power_on) && $stable(rsp_auto_cycle))
      else $error("stalled item changed");

   a_numbers_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_mode_number != '0) && (rsp_scheme_number != '0))
      else $error("mode or scheme number is zero");

   a_auto_cycle_scheme: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_auto_cycle |-> rsp_scheme_number == NUMBER_FIRST)
      else $error("auto-cycle set with scheme other than first");

endmodule

bind button_hold_classifier_core bhc_checker u_bhc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_action        (rsp_action),
   .rsp_power_on      (rsp_power_on),
   .rsp_mode_number   (rsp_mode_number),
   .rsp_scheme_number (rsp_scheme_number),
   .rsp_auto_cycle    (rsp_auto_cycle)
);

// ----- tb/sv/button_hold_classifier_core_tb.sv -----
// Testbench for button_hold_classifier_core: directed hold, glitch and wrap
// checks, then random press sequences under mixed input idling and output stalls.
// Depends on bhc_pkg and the core; results are checked against an in-bench predictor.
`timescale 1ns / 1ps

module button_hold_classifier_core_tb;
   import bhc_pkg::*;

   localparam int   CYCLE_LIMIT    = 1_000_000;
   localparam int   DRAIN_CYCLES   = 4;
   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

   typedef struct packed {
      action_type             action;
      logic                   power_on;
      logic [COUNT_W-1:0]     mode_number;
      logic [COUNT_W-1:0]     scheme_number;
      logic                   auto_cycle;
   } tick_report_type;

   logic                   clock;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic                   req_button_level = LEVEL_RELEASED;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic [1:0]             rsp_action;
   logic                   rsp_power_on;
   logic [COUNT_W-1:0]     rsp_mode_number;
   logic [COUNT_W-1:0]     rsp_scheme_number;
   logic                   rsp_auto_cycle;
   logic                   csr_valid        = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [LIMIT_W-1:0]     csr_wdata        = '0;

   // predictor state and its copy of the registers
   logic [HOLD_WIDTH_DEF-1:0] hold_ticks;
   logic                      was_pressed;
   logic                      power_level;
   logic                      auto_on;
   logic [COUNT_W-1:0]        mode_now;
   logic [COUNT_W-1:0]        scheme_now;
   logic [COUNT_W-1:0]        mode_top;
   logic [COUNT_W-1:0]        scheme_top;
   logic [LIMIT_W-1:0]        short_limit;
   logic [LIMIT_W-1:0]        medium_limit;
   logic [LIMIT_W-1:0]        long_limit;

   tick_report_type pending_reports[$];

   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int error_count     = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int cycle_count     = 0;
   int action_seen[4]  = '{0, 0, 0, 0};

   button_hold_classifier_core #(
      .HOLD_WIDTH(HOLD_WIDTH_DEF)
   ) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_button_level  (req_button_level),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_power_on      (rsp_power_on),
      .rsp_mode_number   (rsp_mode_number),
      .rsp_scheme_number (rsp_scheme_number),
      .rsp_auto_cycle    (rsp_auto_cycle),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_reports.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic void reset_predictor();
      hold_ticks   = '0;
      was_pressed  = 1'b0;
      power_level  = 1'b1;
      auto_on      = 1'b0;
      mode_now     = NUMBER_FIRST;
      scheme_now   = NUMBER_FIRST;
      mode_top     = MODE_COUNT_RST;
      scheme_top   = SCHEME_COUNT_RST;
      short_limit  = SHORT_LIMIT_RST;
      medium_limit = MEDIUM_LIMIT_RST;
      long_limit   = LONG_LIMIT_RST;
   endfunction

   // one sample: count the hold, classify on the second released tick in a row
   function automatic tick_report_type predict_tick(input logic level);
      logic            pressed;
      logic [4:0]      next_num;
      tick_report_type rep;
      pressed    = (level == LEVEL_PRESSED);
      rep.action = ACT_NONE;
      if (pressed && hold_ticks != '1)
         hold_ticks = hold_ticks + 1'b1;
      if (!pressed && !was_pressed) begin
         if (hold_ticks > long_limit) begin
            power_level = ~power_level;
            rep.action  = ACT_POWER;
         end else if (hold_ticks > medium_limit) begin
            next_num   = {1'b0, mode_now} + 5'd1;
            mode_now   = (next_num > {1'b0, mode_top}) ? NUMBER_FIRST : next_num[3:0];
            rep.action = ACT_MODE;
         end else if (hold_ticks > short_limit) begin
            if (auto_on) begin
               auto_on    = 1'b0;
               scheme_now = NUMBER_FIRST;
            end else begin
               next_num = {1'b0, scheme_now} + 5'd1;
               if (next_num > {1'b0, scheme_top}) begin
                  scheme_now = NUMBER_FIRST;
                  auto_on    = 1'b1;
               end else begin
                  scheme_now = next_num[3:0];
               end
            end
            rep.action = ACT_SCHEME;
         end
         hold_ticks = '0;
      end
      was_pressed       = pressed;
      rep.power_on      = power_level;
      rep.mode_number   = mode_now;
      rep.scheme_number = scheme_now;
      rep.auto_cycle    = auto_on;
      return rep;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR @%0t: %s", $time, what);
      error_count++;
   endtask

   task automatic check_report();
      tick_report_type want;
      if (pending_reports.size() == 0) begin
         report_mismatch("result with no sample waiting");
         return;
      end
      want = pending_reports.pop_front();
      results_checked++;
      action_seen[want.action]++;
      if (rsp_action !== want.action)
         report_mismatch($sformatf("item %0d action got %0d want %s", results_checked,
                                   rsp_action, want.action.name()));
      if (rsp_power_on !== want.power_on)
         report_mismatch($sformatf("item %0d power_on got %b want %b", results_checked,
                                   rsp_power_on, want.power_on));
      if (rsp_mode_number !== want.mode_number)
         report_mismatch($sformatf("item %0d mode got %0d want %0d", results_checked,
                                   rsp_mode_number, want.mode_number));
      if (rsp_scheme_number !== want.scheme_number)
         report_mismatch($sformatf("item %0d scheme got %0d want %0d", results_checked,
                                   rsp_scheme_number, want.scheme_number));
      if (rsp_auto_cycle !== want.auto_cycle)
         report_mismatch($sformatf("item %0d auto_cycle got %b want %b", results_checked,
                                   rsp_auto_cycle, want.auto_cycle));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_report();
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   task automatic send_sample(input logic level);
      int gap;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_button_level <= level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_reports.push_back(predict_tick(level));
      items_sent++;
   endtask

   // presses, an optional lone release before press number glitch_at, then releases
   task automatic hold_and_release(input int presses, input int glitch_at, input int releases);
      for (int i = 0; i < presses; i++) begin
         if (glitch_at > 0 && i == glitch_at)
            send_sample(LEVEL_RELEASED);
         send_sample(LEVEL_PRESSED);
      end
      repeat (releases) send_sample(LEVEL_RELEASED);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SHORT_LIMIT:  short_limit  = data;
         CSR_MEDIUM_LIMIT: medium_limit = data;
         CSR_LONG_LIMIT:   long_limit   = data;
         CSR_MODE_COUNT:   mode_top     = data[COUNT_W-1:0];
         CSR_SCHEME_COUNT: scheme_top   = data[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_limits(input logic [LIMIT_W-1:0] s_lim, input logic [LIMIT_W-1:0] m_lim,
                               input logic [LIMIT_W-1:0] l_lim, input logic [LIMIT_W-1:0] mode_w,
                               input logic [LIMIT_W-1:0] scheme_w);
      drain_results();
      write_csr(CSR_SHORT_LIMIT, s_lim);
      write_csr(CSR_MEDIUM_LIMIT, m_lim);
      write_csr(CSR_LONG_LIMIT, l_lim);
      write_csr(CSR_MODE_COUNT, mode_w);
      write_csr(CSR_SCHEME_COUNT, scheme_w);
      csr_valid <= 1'b0;
   endtask

   task automatic test_default_limits();
      repeat (3) send_sample(LEVEL_RELEASED);
      hold_and_release(11, 0, 2);
      hold_and_release(10, 0, 2);
      hold_and_release(101, 0, 2);
   endtask

   task automatic test_glitch_hold();
      apply_limits(16'd1, 16'd3, 16'd5, 16'd11, 16'd13);
      hold_and_release(4, 2, 2);
      hold_and_release(2, 1, 3);
      hold_and_release(1, 0, 2);
      hold_and_release(0, 0, 2);
   endtask

   task automatic test_scheme_wrap();
      apply_limits(16'd1, 16'd3, 16'd5, 16'd11, 16'd2);
      repeat (5) hold_and_release(2, 0, 2);
   endtask

   task automatic test_count_limits();
      apply_limits(16'd1, 16'd3, 16'd5, 16'd15, 16'd15);
      repeat (16) hold_and_release(4, 0, 2);
      repeat (17) hold_and_release(2, 0, 2);
      repeat (4) hold_and_release(4, 0, 2);
      apply_limits(16'd1, 16'd3, 16'd5, 16'd2, 16'd15);
      hold_and_release(4, 0, 2);
      apply_limits(16'd1, 16'd3, 16'd5, 16'd0, 16'd0);
      repeat (2) hold_and_release(4, 0, 2);
      repeat (3) hold_and_release(2, 0, 2);
   endtask

   task automatic test_csr_extremes();
      apply_limits(16'd0, 16'd0, 16'd0, 16'hFFF1, 16'hFFF1);
      hold_and_release(1, 0, 2);
      hold_and_release(0, 0, 3);
      apply_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      hold_and_release(3, 0, 2);
      drain_results();
      for (int i = int'(CSR_SCHEME_COUNT) + 1; i < (1 << CSR_INDEX_W); i++)
         write_csr(CSR_INDEX_W'(i), 16'h0000);
      csr_valid <= 1'b0;
      hold_and_release(3, 0, 2);
   endtask

   task automatic randomize_limits();
      int s_lim;
      int m_lim;
      int l_lim;
      s_lim = $urandom_range(0, 5);
      m_lim = s_lim + $urandom_range(0, 6);
      l_lim = m_lim + $urandom_range(0, 10);
      if ($urandom_range(0, 9) == 0)
         l_lim = $urandom_range(0, 6);
      apply_limits(LIMIT_W'(s_lim), LIMIT_W'(m_lim), LIMIT_W'(l_lim),
                   {12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15))},
                   {12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15))});
   endtask

   task automatic test_random_holds(input int idle_pct, input int stall_pct, input int target);
      int first;
      int next_setting;
      int span;
      int hold;
      int glitch;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      first          = items_sent;
      next_setting   = 0;
      while (items_sent - first < target) begin
         if (items_sent - first >= next_setting) begin
            randomize_limits();
            next_setting += target / 3;
         end
         if ($urandom_range(0, 99) < 85) begin
            span = int'(long_limit);
            if (int'(medium_limit) > span) span = int'(medium_limit);
            if (int'(short_limit) > span) span = int'(short_limit);
            hold   = $urandom_range(0, span + 3);
            glitch = (hold >= 2 && $urandom_range(0, 4) == 0) ? $urandom_range(1, hold - 1) : 0;
            hold_and_release(hold, glitch, $urandom_range(2, 3));
         end else begin
            repeat ($urandom_range(1, 6)) send_sample(1'($urandom_range(0, 1)));
         end
      end
   endtask

   initial begin
      reset_predictor();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 12;
      recv_stall_pct = 52;
      test_default_limits();
      test_glitch_hold();
      test_scheme_wrap();
      test_count_limits();
      test_csr_extremes();

      test_random_holds(12, 52, 150);
      test_random_holds(52, 12, 150);
      test_random_holds(0, 0, 150);
      drain_results();

      $display("Sent %0d samples and checked %0d results over directed and random holds.",
               items_sent, results_checked);
      $display("Actions seen: none %0d, scheme %0d, mode %0d, power %0d.",
               action_seen[ACT_NONE], action_seen[ACT_SCHEME], action_seen[ACT_MODE],
               action_seen[ACT_POWER]);
      if (error_count == 0 && pending_reports.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
